### hdl/utilization_batch_governor_unit_assert.svh
// Assertion helpers used by the governor RTL.
`ifndef UTILIZATION_BATCH_GOVERNOR_UNIT_ASSERT_SVH
`define UTILIZATION_BATCH_GOVERNOR_UNIT_ASSERT_SVH

// same-cycle implication
`define UBG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ubg assertion failed");

// next-cycle implication
`define UBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ubg assertion failed");

`endif

### hdl/ubg_pkg.sv
package ubg_pkg;

    localparam int WINDOW_LEN_DEF    = 10;
    localparam int HISTORY_LIMIT_DEF = 600;
    localparam int MIN_BATCH_DEF     = 32;

    localparam int UTIL_W  = 14;
    localparam int MEM_W   = 20;
    localparam int TEMP_W  = 12;
    localparam int BATCH_W = 16;
    localparam int WORK_W  = 8;
    localparam int COUNT_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BATCH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WORKERS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_UP_UTIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DOWN_UTIL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_RESERVE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UP_HEADROOM      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WORKERS      = 3'd7;

    localparam logic [BATCH_W-1:0] RST_INITIAL_BATCH   = 16'd32;
    localparam logic [WORK_W-1:0]  RST_INITIAL_WORKERS = 8'd1;
    localparam logic [UTIL_W-1:0]  RST_SCALE_UP_UTIL   = 14'd6000;
    localparam logic [UTIL_W-1:0]  RST_SCALE_DOWN_UTIL = 14'd8500;
    localparam logic [TEMP_W-1:0]  RST_THROTTLE_TEMP   = 12'd900;
    localparam logic [BATCH_W-1:0] RST_MEMORY_RESERVE  = 16'd256;
    localparam logic [BATCH_W-1:0] RST_UP_HEADROOM     = 16'd100;
    localparam logic [WORK_W-1:0]  RST_MAX_WORKERS     = 8'd8;

    typedef enum logic [1:0] {
        ACT_HOLD     = 2'd0,
        ACT_UP       = 2'd1,
        ACT_DOWN     = 2'd2,
        ACT_THROTTLE = 2'd3
    } t_action;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hdl/ubg_ram.sv
module ubg_ram
    import ubg_pkg::*;
#(
    parameter int WIDTH = 14,
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ubg_div.sv
// Restoring divider, one quotient bit per cycle.
module ubg_div
    import ubg_pkg::*;
#(
    parameter int NUM_W = 18,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_quo;

    logic [DEN_W:0]    w_rem_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // dividend bits shift out of r_quo's top while quotient bits enter at the bottom
    always_comb begin
        w_rem_sh = {r_rem, r_quo[NUM_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= '0;
            r_quo  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(NUM_W);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

### hdl/utilization_batch_governor_unit.sv
// Utilization batch governor. Takes one telemetry word at a time and returns one
// recommendation word for it. After a word is taken, the sequencer reads the last
// n = min(samples, WINDOW_LEN) utilizations out of the window RAM one per cycle,
// forms the threshold products, then runs a bit-serial divider for the mean
// (one quotient bit per cycle, 14 + clog2(WINDOW_LEN+1) bits). The steps from one
// taken word to the next are: sum, products, divider, loading the result, taking
// the next word. A finished result waits in an output register, so the next word is
// taken while it is still unclaimed; a result that finds that register still
// occupied waits, and stalls the input, until it is claimed. Writing register 0
// or 1 restarts the window and reloads the recommendations.
`include "utilization_batch_governor_unit_assert.svh"

module utilization_batch_governor_unit
    import ubg_pkg::*;
#(
    parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
    parameter int HISTORY_LIMIT = HISTORY_LIMIT_DEF,
    parameter int MIN_BATCH     = MIN_BATCH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample input
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [UTIL_W-1:0]        i_utilization,
    input  logic [MEM_W-1:0]         i_memory_used_mb,
    input  logic [MEM_W-1:0]         i_memory_total_mb,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [BATCH_W-1:0]       i_current_batch,
    input  logic [WORK_W-1:0]        i_current_workers,
    // result output
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_action,
    output logic [BATCH_W-1:0]       o_advised_batch,
    output logic [WORK_W-1:0]        o_advised_workers,
    output logic [UTIL_W-1:0]        o_average_utilization,
    output logic [COUNT_W-1:0]       o_sample_count,
    // register writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = UTIL_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [BATCH_W-1:0]       r_init_batch;
    logic [WORK_W-1:0]        r_init_workers;
    logic [UTIL_W-1:0]        r_scale_up;
    logic [UTIL_W-1:0]        r_scale_down;
    logic signed [TEMP_W-1:0] r_throttle_temp;
    logic [BATCH_W-1:0]       r_reserve;
    logic [BATCH_W-1:0]       r_headroom;
    logic [WORK_W-1:0]        r_max_workers;

    // governor state
    logic [IDX_W-1:0]   r_wptr;
    logic [CNT_W-1:0]   r_fill;
    logic [COUNT_W-1:0] r_seen;
    logic [BATCH_W-1:0] r_batch_rec;
    logic [WORK_W-1:0]  r_work_rec;

    // captured sample
    logic [MEM_W-1:0]         r_used;
    logic [MEM_W-1:0]         r_total;
    logic signed [TEMP_W-1:0] r_temp;
    logic [BATCH_W-1:0]       r_cur_batch;
    logic [WORK_W-1:0]        r_cur_workers;

    // working registers
    logic [CNT_W-1:0]  r_rd_cnt;
    logic              r_rd_pend;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_up_lim;
    logic [SUM_W-1:0]  r_dn_lim;
    logic              r_hot;
    logic              r_low_mem;
    logic              r_room;
    logic [UTIL_W-1:0] r_mean;

    // result register
    logic               r_out_valid;
    t_action            r_out_action;
    logic [BATCH_W-1:0] r_out_batch;
    logic [WORK_W-1:0]  r_out_workers;
    logic [UTIL_W-1:0]  r_out_mean;
    logic [COUNT_W-1:0] r_out_count;

    logic [CNT_W-1:0]   n_fill;
    logic [UTIL_W-1:0]  w_rdata;
    logic               w_in_take;
    logic               w_out_take;
    logic               w_out_load;
    logic               w_div_start;
    t_div_stat          w_div_stat;
    logic [SUM_W-1:0]   w_quot;

    logic signed [MEM_W:0]   w_free;
    logic signed [MEM_W+1:0] w_over;
    t_action                 w_action;
    logic [BATCH_W-1:0]      w_batch;
    logic [WORK_W-1:0]       w_workers;
    logic [BATCH_W:0]        w_grow;

    assign w_in_take   = i_valid && (r_state == S_IDLE);
    assign w_out_take  = r_out_valid && !i_stall;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign w_div_start = (r_state == S_MUL);
    assign n_fill      = (r_fill < CNT_W'(WINDOW_LEN)) ? r_fill + 1'b1 : r_fill;

    ubg_ram #(
        .WIDTH (UTIL_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_in_take),
        .i_waddr (r_wptr),
        .i_wdata (i_utilization),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    ubg_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_sum),
        .i_den   (r_fill),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // memory tests, registered in S_MUL
    always_comb begin
        w_free = $signed({1'b0, r_total}) - $signed({1'b0, r_used});
        w_over = {w_free[MEM_W], w_free} - $signed({{(MEM_W+2-BATCH_W){1'b0}}, r_reserve});
    end

    // priority decision; the window holds at least one sample here unless register 0 or 1 was written meanwhile
    always_comb begin
        w_action  = ACT_HOLD;
        w_batch   = r_batch_rec;
        w_workers = r_work_rec;
        w_grow    = {1'b0, r_cur_batch} + {4'b0, r_cur_batch[BATCH_W-1:3]};
        if (r_hot) begin
            w_action = ACT_THROTTLE;
            w_batch  = (r_cur_batch > BATCH_W'(MIN_BATCH))
                     ? r_cur_batch - {2'b0, r_cur_batch[BATCH_W-1:2]} : BATCH_W'(MIN_BATCH);
        end else if (r_low_mem) begin
            w_action = ACT_DOWN;
            w_batch  = (r_cur_batch > BATCH_W'(MIN_BATCH))
                     ? r_cur_batch - {3'b0, r_cur_batch[BATCH_W-1:3]} : BATCH_W'(MIN_BATCH);
        end else if (r_sum < r_up_lim) begin
            if (r_room) begin
                w_action  = ACT_UP;
                w_batch   = w_grow[BATCH_W] ? {BATCH_W{1'b1}} : w_grow[BATCH_W-1:0];
                w_workers = (r_cur_workers < r_max_workers)
                          ? r_cur_workers + 1'b1 : r_max_workers;
            end
        end else if (r_sum > r_dn_lim) begin
            w_action = ACT_DOWN;
            w_batch  = (r_cur_batch > BATCH_W'(MIN_BATCH))
                     ? r_cur_batch - {4'b0, r_cur_batch[BATCH_W-1:4]} : BATCH_W'(MIN_BATCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_init_batch    <= RST_INITIAL_BATCH;
            r_init_workers  <= RST_INITIAL_WORKERS;
            r_scale_up      <= RST_SCALE_UP_UTIL;
            r_scale_down    <= RST_SCALE_DOWN_UTIL;
            r_throttle_temp <= RST_THROTTLE_TEMP;
            r_reserve       <= RST_MEMORY_RESERVE;
            r_headroom      <= RST_UP_HEADROOM;
            r_max_workers   <= RST_MAX_WORKERS;
            r_wptr          <= '0;
            r_fill          <= '0;
            r_seen          <= '0;
            r_batch_rec     <= RST_INITIAL_BATCH;
            r_work_rec      <= RST_INITIAL_WORKERS;
            r_rd_cnt        <= '0;
            r_rd_pend       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // a new result may replace the one claimed at this edge
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_used        <= i_memory_used_mb;
                        r_total       <= i_memory_total_mb;
                        r_temp        <= i_temperature;
                        r_cur_batch   <= i_current_batch;
                        r_cur_workers <= i_current_workers;
                        r_wptr        <= (r_wptr == IDX_W'(WINDOW_LEN - 1)) ? '0 : r_wptr + 1'b1;
                        r_fill        <= n_fill;
                        if (r_seen < COUNT_W'(HISTORY_LIMIT)) begin
                            r_seen <= r_seen + 1'b1;
                        end
                        r_rd_cnt  <= '0;
                        r_rd_pend <= 1'b0;
                        r_sum     <= '0;
                        r_state   <= S_SUM;
                    end
                end
                S_SUM: begin
                    // window entries 0..n-1 are exactly the last n samples
                    if (r_rd_cnt < r_fill) begin
                        r_rd_cnt  <= r_rd_cnt + 1'b1;
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_rd_pend <= 1'b0;
                    end
                    if (r_rd_pend) begin
                        r_sum <= r_sum + SUM_W'(w_rdata);
                    end
                    if (r_rd_cnt == r_fill && !r_rd_pend) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_up_lim  <= {{CNT_W{1'b0}}, r_scale_up} * {{UTIL_W{1'b0}}, r_fill};
                    r_dn_lim  <= {{CNT_W{1'b0}}, r_scale_down} * {{UTIL_W{1'b0}}, r_fill};
                    r_hot     <= (r_temp >= r_throttle_temp);
                    r_low_mem <= (w_free < $signed({{(MEM_W+1-BATCH_W){1'b0}}, r_reserve}));
                    r_room    <= (w_over > $signed({{(MEM_W+2-BATCH_W){1'b0}}, r_headroom}));
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_mean  <= w_quot[UTIL_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_batch_rec   <= w_batch;
                        r_work_rec    <= w_workers;
                        r_out_action  <= w_action;
                        r_out_batch   <= w_batch;
                        r_out_workers <= w_workers;
                        r_out_mean    <= r_mean;
                        r_out_count   <= r_seen;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INITIAL_BATCH: begin
                        r_init_batch <= i_cfg_data;
                        r_batch_rec  <= i_cfg_data;
                        r_work_rec   <= r_init_workers;
                        r_wptr       <= '0;
                        r_fill       <= '0;
                        r_seen       <= '0;
                    end
                    REG_INITIAL_WORKERS: begin
                        r_init_workers <= i_cfg_data[WORK_W-1:0];
                        r_batch_rec    <= r_init_batch;
                        r_work_rec     <= i_cfg_data[WORK_W-1:0];
                        r_wptr         <= '0;
                        r_fill         <= '0;
                        r_seen         <= '0;
                    end
                    REG_SCALE_UP_UTIL:   r_scale_up      <= i_cfg_data[UTIL_W-1:0];
                    REG_SCALE_DOWN_UTIL: r_scale_down    <= i_cfg_data[UTIL_W-1:0];
                    REG_THROTTLE_TEMP:   r_throttle_temp <= i_cfg_data[TEMP_W-1:0];
                    REG_MEMORY_RESERVE:  r_reserve       <= i_cfg_data;
                    REG_UP_HEADROOM:     r_headroom      <= i_cfg_data;
                    REG_MAX_WORKERS:     r_max_workers   <= i_cfg_data[WORK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stall               = (r_state != S_IDLE);
    assign o_valid               = r_out_valid;
    assign o_action              = r_out_action;
    assign o_advised_batch       = r_out_batch;
    assign o_advised_workers     = r_out_workers;
    assign o_average_utilization = r_out_mean;
    assign o_sample_count        = r_out_count;
    assign o_cfg_ready           = 1'b1;

    // a taken word keeps the sequencer busy on the next cycle
    `UBG_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, w_in_take, o_stall)
    `UBG_ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(WINDOW_LEN))
    // divider finishes only while the sequencer waits for it
    `UBG_ASSERT_IMPLY(a_div_owner, i_clk, i_rst_n, w_div_stat.done, r_state == S_DIV)

endmodule

### tb/governor_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the governor, predicts
// every result word and compares it field by field with what comes out.
module governor_checker
    import ubg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_smp_valid,
    input  logic                     i_smp_stall,
    input  logic [UTIL_W-1:0]        i_utilization,
    input  logic [MEM_W-1:0]         i_memory_used_mb,
    input  logic [MEM_W-1:0]         i_memory_total_mb,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [BATCH_W-1:0]       i_current_batch,
    input  logic [WORK_W-1:0]        i_current_workers,
    // result channel
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [1:0]               i_action,
    input  logic [BATCH_W-1:0]       i_advised_batch,
    input  logic [WORK_W-1:0]        i_advised_workers,
    input  logic [UTIL_W-1:0]        i_average_utilization,
    input  logic [COUNT_W-1:0]       i_sample_count,
    // register channel
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // status for the stimulus side
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_up_count,
    output int                       o_down_count,
    output int                       o_throttle_count
);

    typedef struct packed {
        t_action              action;
        logic [BATCH_W-1:0]   batch;
        logic [WORK_W-1:0]    workers;
        logic [UTIL_W-1:0]    average;
        logic [COUNT_W-1:0]   count;
    } t_rec;

    t_rec recs_due[$];

    // governor state
    logic [UTIL_W-1:0]        util_hist [WINDOW_LEN_DEF];
    int                       hist_wr;
    int                       samples_seen;
    logic [BATCH_W-1:0]       batch_rec;
    logic [WORK_W-1:0]        workers_rec;

    // register copies
    logic [BATCH_W-1:0]       r_init_batch;
    logic [WORK_W-1:0]        r_init_workers;
    logic [UTIL_W-1:0]        r_up_util;
    logic [UTIL_W-1:0]        r_down_util;
    logic signed [TEMP_W-1:0] r_throttle;
    logic [BATCH_W-1:0]       r_reserve;
    logic [BATCH_W-1:0]       r_headroom;
    logic [WORK_W-1:0]        r_max_workers;

    int fails = 0;
    int checked = 0;
    int n_up = 0;
    int n_down = 0;
    int n_throttle = 0;
    t_rec want_rec;
    t_rec next_rec;

    task automatic restart_window();
        hist_wr      = 0;
        samples_seen = 0;
        batch_rec    = r_init_batch;
        workers_rec  = r_init_workers;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_INITIAL_BATCH: begin
                r_init_batch = data;
                restart_window();
            end
            REG_INITIAL_WORKERS: begin
                r_init_workers = data[WORK_W-1:0];
                restart_window();
            end
            REG_SCALE_UP_UTIL:   r_up_util     = data[UTIL_W-1:0];
            REG_SCALE_DOWN_UTIL: r_down_util   = data[UTIL_W-1:0];
            REG_THROTTLE_TEMP:   r_throttle    = data[TEMP_W-1:0];
            REG_MEMORY_RESERVE:  r_reserve     = data;
            REG_UP_HEADROOM:     r_headroom    = data;
            REG_MAX_WORKERS:     r_max_workers = data[WORK_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int shrink_batch(int cur, int divisor);
        return (cur > MIN_BATCH_DEF) ? cur - cur / divisor : MIN_BATCH_DEF;
    endfunction

    // one telemetry sample in, one recommendation out
    task automatic govern_sample(
        input  logic [UTIL_W-1:0]        util,
        input  logic [MEM_W-1:0]         used,
        input  logic [MEM_W-1:0]         total,
        input  logic signed [TEMP_W-1:0] temp,
        input  logic [BATCH_W-1:0]       cur_batch,
        input  logic [WORK_W-1:0]        cur_workers,
        output t_rec                     rec
    );
        int n;
        int sum;
        int free_mb;
        int grown;
        int i;
        util_hist[hist_wr] = util;
        hist_wr = (hist_wr + 1) % WINDOW_LEN_DEF;
        if (samples_seen < HISTORY_LIMIT_DEF)
            samples_seen++;
        n = (samples_seen < WINDOW_LEN_DEF) ? samples_seen : WINDOW_LEN_DEF;
        sum = 0;
        for (i = 0; i < n; i++)
            sum += int'(util_hist[(hist_wr + WINDOW_LEN_DEF - 1 - i) % WINDOW_LEN_DEF]);
        free_mb = int'(total) - int'(used);
        rec.action = ACT_HOLD;

        if (temp >= r_throttle) begin
            batch_rec  = BATCH_W'(shrink_batch(int'(cur_batch), 4));
            rec.action = ACT_THROTTLE;
        end else if (free_mb < int'(r_reserve)) begin
            batch_rec  = BATCH_W'(shrink_batch(int'(cur_batch), 8));
            rec.action = ACT_DOWN;
        end else if (sum < int'(r_up_util) * n) begin
            // a low mean without headroom holds and skips the high-mean test
            if (free_mb - int'(r_reserve) > int'(r_headroom)) begin
                grown = int'(cur_batch) + int'(cur_batch) / 8;
                batch_rec   = (grown > 65535) ? 16'hFFFF : grown[BATCH_W-1:0];
                workers_rec = (cur_workers < r_max_workers) ? cur_workers + 8'd1
                                                             : r_max_workers;
                rec.action  = ACT_UP;
            end
        end else if (sum > int'(r_down_util) * n) begin
            batch_rec  = BATCH_W'(shrink_batch(int'(cur_batch), 16));
            rec.action = ACT_DOWN;
        end

        rec.batch   = batch_rec;
        rec.workers = workers_rec;
        rec.average = UTIL_W'(sum / n);
        rec.count   = COUNT_W'(samples_seen);
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_batch   = RST_INITIAL_BATCH;
            r_init_workers = RST_INITIAL_WORKERS;
            r_up_util      = RST_SCALE_UP_UTIL;
            r_down_util    = RST_SCALE_DOWN_UTIL;
            r_throttle     = RST_THROTTLE_TEMP;
            r_reserve      = RST_MEMORY_RESERVE;
            r_headroom     = RST_UP_HEADROOM;
            r_max_workers  = RST_MAX_WORKERS;
            restart_window();
            recs_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);

            if (i_res_valid && !i_res_stall) begin
                if (recs_due.size() == 0) begin
                    $display("%0t: result word with nothing expected, action %0d batch %0d",
                             $time, i_action, i_advised_batch);
                    fails++;
                end else begin
                    want_rec = recs_due.pop_front();
                    compare_field("action", want_rec.action, i_action);
                    compare_field("advised_batch", want_rec.batch, i_advised_batch);
                    compare_field("advised_workers", want_rec.workers, i_advised_workers);
                    compare_field("average_utilization", want_rec.average,
                                  i_average_utilization);
                    compare_field("sample_count", want_rec.count, i_sample_count);
                    checked++;
                    case (want_rec.action)
                        ACT_UP:       n_up++;
                        ACT_DOWN:     n_down++;
                        ACT_THROTTLE: n_throttle++;
                        default: ;
                    endcase
                end
            end

            if (i_smp_valid && !i_smp_stall) begin
                govern_sample(i_utilization, i_memory_used_mb, i_memory_total_mb,
                              i_temperature, i_current_batch, i_current_workers, next_rec);
                recs_due.push_back(next_rec);
            end
        end
        o_pending        <= recs_due.size();
        o_fail_count     <= fails;
        o_checked        <= checked;
        o_up_count       <= n_up;
        o_down_count     <= n_down;
        o_throttle_count <= n_throttle;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ubg_pkg::*;

    typedef struct {
        logic [UTIL_W-1:0]        util;
        logic [MEM_W-1:0]         used;
        logic [MEM_W-1:0]         total;
        logic signed [TEMP_W-1:0] temp;
        logic [BATCH_W-1:0]       batch;
        logic [WORK_W-1:0]        workers;
    } t_sample;

    localparam int MEM_MAX = (1 << MEM_W) - 1;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [UTIL_W-1:0]        i_utilization = '0;
    logic [MEM_W-1:0]         i_memory_used_mb = '0;
    logic [MEM_W-1:0]         i_memory_total_mb = '0;
    logic signed [TEMP_W-1:0] i_temperature = '0;
    logic [BATCH_W-1:0]       i_current_batch = '0;
    logic [WORK_W-1:0]        i_current_workers = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [1:0]               o_action;
    logic [BATCH_W-1:0]       o_advised_batch;
    logic [WORK_W-1:0]        o_advised_workers;
    logic [UTIL_W-1:0]        o_average_utilization;
    logic [COUNT_W-1:0]       o_sample_count;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = REG_INITIAL_BATCH;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int up_seen;
    int down_seen;
    int throttle_seen;

    // copies of the thresholds, used only to aim the random samples
    int sh_up   = RST_SCALE_UP_UTIL;
    int sh_down = RST_SCALE_DOWN_UTIL;
    int sh_thr  = $signed(RST_THROTTLE_TEMP);
    int sh_res  = RST_MEMORY_RESERVE;
    int sh_head = RST_UP_HEADROOM;
    int sh_maxw = RST_MAX_WORKERS;
    int trend   = 5000;
    bit calm_tx = 1'b0;
    bit calm_rx = 1'b0;
    int sent = 0;
    int cfg_writes = 0;

    utilization_batch_governor_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_utilization         (i_utilization),
        .i_memory_used_mb      (i_memory_used_mb),
        .i_memory_total_mb     (i_memory_total_mb),
        .i_temperature         (i_temperature),
        .i_current_batch       (i_current_batch),
        .i_current_workers     (i_current_workers),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_action              (o_action),
        .o_advised_batch       (o_advised_batch),
        .o_advised_workers     (o_advised_workers),
        .o_average_utilization (o_average_utilization),
        .o_sample_count        (o_sample_count),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    governor_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_smp_valid           (i_valid),
        .i_smp_stall           (o_stall),
        .i_utilization         (i_utilization),
        .i_memory_used_mb      (i_memory_used_mb),
        .i_memory_total_mb     (i_memory_total_mb),
        .i_temperature         (i_temperature),
        .i_current_batch       (i_current_batch),
        .i_current_workers     (i_current_workers),
        .i_res_valid           (o_valid),
        .i_res_stall           (i_stall),
        .i_action              (o_action),
        .i_advised_batch       (o_advised_batch),
        .i_advised_workers     (o_advised_workers),
        .i_average_utilization (o_average_utilization),
        .i_sample_count        (o_sample_count),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_fail_count          (fail_count),
        .o_pending             (pending),
        .o_checked             (checked),
        .o_up_count            (up_seen),
        .o_down_count          (down_seen),
        .o_throttle_count      (throttle_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return rnd(0, 16);
    endfunction

    function automatic t_sample mk(int u, int used, int tot, int t, int b, int w);
        t_sample s;
        s.util    = u[UTIL_W-1:0];
        s.used    = used[MEM_W-1:0];
        s.total   = tot[MEM_W-1:0];
        s.temp    = t[TEMP_W-1:0];
        s.batch   = b[BATCH_W-1:0];
        s.workers = w[WORK_W-1:0];
        return s;
    endfunction

    // utilization mostly follows a drifting level so the window mean crosses
    // the thresholds; temperature and free memory are aimed at their limits
    function automatic t_sample rand_sample();
        int u;
        int t;
        int fr;
        int used;
        int tot;
        int b;
        int w;
        case (rnd(0, 9))
            6: trend = sh_up + rnd(-200, 200);
            7: trend = sh_down + rnd(-200, 200);
            default: trend = trend + rnd(-400, 400);
        endcase
        trend = clamp(trend, 0, 10000);
        case (rnd(0, 9))
            8: u = rnd(0, 16383);
            9: begin
                case (rnd(0, 3))
                    0: u = 0;
                    1: u = 10000;
                    2: u = 16383;
                    default: u = rnd(10001, 16383);
                endcase
            end
            default: u = clamp(trend + rnd(-100, 100), 0, 10000);
        endcase

        case (rnd(0, 7))
            0: t = sh_thr + rnd(0, 100);
            1: t = sh_thr - rnd(0, 1);
            2: t = rnd(-2048, 2047);
            default: t = sh_thr - rnd(1, 600);
        endcase
        t = clamp(t, -2048, 2047);

        case (rnd(0, 7))
            0: fr = -rnd(1, MEM_MAX);
            1: fr = sh_res - rnd(1, 300);
            2: fr = sh_res + sh_head + rnd(-2, 2);
            3: fr = rnd(0, MEM_MAX);
            default: fr = sh_res + sh_head + rnd(1, 200000);
        endcase
        fr = clamp(fr, -MEM_MAX, MEM_MAX);
        if (fr >= 0) begin
            tot  = rnd(fr, MEM_MAX);
            used = tot - fr;
        end else begin
            used = rnd(-fr, MEM_MAX);
            tot  = used + fr;
        end

        case (rnd(0, 5))
            0: b = rnd(0, 40);
            1: b = rnd(65000, 65535);
            default: b = rnd(0, 65535);
        endcase
        case (rnd(0, 4))
            0: w = clamp(sh_maxw + rnd(-2, 2), 0, 255);
            1: w = rnd(0, 1) * 255;
            default: w = rnd(0, 255);
        endcase
        return mk(u, used, tot, t, b, w);
    endfunction

    // valid is raised here and left high when the next word follows at once
    task automatic send_sample(input t_sample s);
        int gap;
        i_valid           <= 1'b1;
        i_utilization     <= s.util;
        i_memory_used_mb  <= s.used;
        i_memory_total_mb <= s.total;
        i_temperature     <= s.temp;
        i_current_batch   <= s.batch;
        i_current_workers <= s.workers;
        do @(posedge i_clk); while (o_stall);
        sent++;
        gap = draw_wait(calm_tx);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input bit last);
        logic [CFG_DATA_W-1:0] data;
        data = value[CFG_DATA_W-1:0];
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last)
            i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_SCALE_UP_UTIL:   sh_up   = data[UTIL_W-1:0];
            REG_SCALE_DOWN_UTIL: sh_down = data[UTIL_W-1:0];
            REG_THROTTLE_TEMP:   sh_thr  = $signed(data[TEMP_W-1:0]);
            REG_MEMORY_RESERVE:  sh_res  = data;
            REG_UP_HEADROOM:     sh_head = data;
            REG_MAX_WORKERS:     sh_maxw = data[WORK_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int reg_value(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_INITIAL_BATCH:   return rnd(0, 65535);
            REG_INITIAL_WORKERS: return rnd(0, 255);
            REG_SCALE_UP_UTIL:   return rnd(2000, 9000);
            REG_SCALE_DOWN_UTIL: return rnd(5000, 10000);
            REG_THROTTLE_TEMP:   return (rnd(-400, 1500) & 12'hFFF) | (rnd(0, 15) << TEMP_W);
            REG_MEMORY_RESERVE:  return rnd(0, 5000);
            REG_UP_HEADROOM:     return rnd(0, 5000);
            default:             return rnd(1, 255);
        endcase
    endfunction

    task automatic run_random(input int items);
        int i;
        for (i = 0; i < items; i++) begin
            if (i % 50 == 0) begin
                calm_tx = (rnd(0, 4) == 0);
                calm_rx = (rnd(0, 4) == 0);
            end
            if (rnd(0, 99) == 0)
                wait_drained();
            send_sample(rand_sample());
        end
    endtask

    // result side: a random stall, possibly none, before every word
    initial begin
        int hold;
        forever begin
            hold = draw_wait(calm_rx);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    initial begin
        int i;
        int k;
        int writes;
        logic [CFG_IDX_W-1:0] idx;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default registers
        send_sample(mk(0, 0, MEM_MAX, 250, 65535, 7));       // scale up, batch saturates
        send_sample(mk(0, 1000, 100000, 250, 40, 200));      // excess workers pulled to cap
        send_sample(mk(16383, 0, 0, 250, 32, 3));            // no free memory, batch floor
        send_sample(mk(10000, MEM_MAX, 0, -2048, 1000, 1));  // used above total
        send_sample(mk(5000, 0, 255, 0, 33, 1));             // one below reserve
        send_sample(mk(0, 0, 356, 0, 100, 0));               // headroom just short: hold
        send_sample(mk(0, 0, 357, 0, 100, 0));               // headroom just enough
        send_sample(mk(9000, 0, MEM_MAX, 900, 32, 5));       // throttle at limit
        send_sample(mk(9000, 0, MEM_MAX, 899, 65535, 5));
        send_sample(mk(9000, 0, MEM_MAX, 2047, 65535, 255));
        send_sample(mk(9000, 0, MEM_MAX, 1500, 20, 255));
        send_sample(mk(9000, 0, MEM_MAX, -400, 0, 255));
        for (i = 0; i < 10; i++)                             // high mean, window wraps
            send_sample(mk(10000, 0, 500000, 200, i * 7000 + 33, 8));

        // long run on reset settings: sample count saturates
        wait_drained();
        run_random(700);

        // low extremes
        wait_drained();
        set_reg(REG_INITIAL_BATCH, 0, 1'b0);
        set_reg(REG_INITIAL_WORKERS, 0, 1'b0);
        set_reg(REG_SCALE_UP_UTIL, 0, 1'b0);
        set_reg(REG_SCALE_DOWN_UTIL, 0, 1'b0);
        set_reg(REG_THROTTLE_TEMP, -400, 1'b0);
        set_reg(REG_MEMORY_RESERVE, 0, 1'b0);
        set_reg(REG_UP_HEADROOM, 0, 1'b0);
        set_reg(REG_MAX_WORKERS, 1, 1'b1);
        run_random(120);

        // high extremes
        wait_drained();
        set_reg(REG_INITIAL_BATCH, 65535, 1'b0);
        set_reg(REG_INITIAL_WORKERS, 255, 1'b0);
        set_reg(REG_SCALE_UP_UTIL, 10000, 1'b0);
        set_reg(REG_SCALE_DOWN_UTIL, 10000, 1'b0);
        set_reg(REG_THROTTLE_TEMP, 1500, 1'b0);
        set_reg(REG_MEMORY_RESERVE, 65535, 1'b0);
        set_reg(REG_UP_HEADROOM, 65535, 1'b0);
        set_reg(REG_MAX_WORKERS, 255, 1'b1);
        run_random(120);

        // out-of-range thresholds, junk above the narrow registers
        wait_drained();
        set_reg(REG_INITIAL_BATCH, 16'h5A5A, 1'b0);
        set_reg(REG_INITIAL_WORKERS, 16'h12FF, 1'b0);
        set_reg(REG_SCALE_UP_UTIL, 16'hFFFF, 1'b0);
        set_reg(REG_SCALE_DOWN_UTIL, 16'h3FFF, 1'b0);
        set_reg(REG_THROTTLE_TEMP, 16'hF7FF, 1'b0);
        set_reg(REG_MEMORY_RESERVE, 0, 1'b0);
        set_reg(REG_UP_HEADROOM, 0, 1'b0);
        set_reg(REG_MAX_WORKERS, 16'hAB00, 1'b1);
        run_random(120);

        // lowest throttle limit: every word throttles
        wait_drained();
        set_reg(REG_THROTTLE_TEMP, 16'h0800, 1'b1);
        run_random(40);

        for (k = 0; k < 4; k++) begin
            wait_drained();
            writes = rnd(2, 8);
            for (i = 0; i < writes; i++) begin
                idx = CFG_IDX_W'($urandom_range(0, REG_MAX_WORKERS));
                set_reg(idx, reg_value(idx), i == writes - 1);
            end
            run_random(100);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d samples across %0d register writes, %0d result words compared.",
                 sent, cfg_writes, checked);
        $display("Actions seen: %0d scale up, %0d scale down, %0d throttle, the rest hold.",
                 up_seen, down_seen, throttle_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/ubg_pkg.sv
hdl/ubg_ram.sv
hdl/ubg_div.sv
hdl/utilization_batch_governor_unit.sv
tb/governor_checker.sv
tb/tb_top.sv
